/* hdl/tcm_pkg.sv */
package tcm_pkg;

    localparam int SLOTS = 8;
    localparam int SLOT_W = 3;

    typedef logic [3:0] cmd_t;
    localparam cmd_t CMD_CONNECT     = 4'd0;
    localparam cmd_t CMD_STATE_REQ   = 4'd1;
    localparam cmd_t CMD_DISC_REQ    = 4'd2;
    localparam cmd_t CMD_DISC_RESP   = 4'd3;
    localparam cmd_t CMD_TUNNEL_REQ  = 4'd4;
    localparam cmd_t CMD_TUNNEL_ACK  = 4'd5;
    localparam cmd_t CMD_SEARCH      = 4'd6;
    localparam cmd_t CMD_TICK        = 4'd7;
    localparam cmd_t CMD_BROADCAST   = 4'd8;

    localparam logic [2:0] KIND_CONNECT_RESP = 3'd0;
    localparam logic [2:0] KIND_STATE_RESP   = 3'd1;
    localparam logic [2:0] KIND_DISC_RESP    = 3'd2;
    localparam logic [2:0] KIND_TUNNEL_ACK   = 3'd3;
    localparam logic [2:0] KIND_TUNNEL_OUT   = 3'd4;
    localparam logic [2:0] KIND_SEARCH_RESP  = 3'd5;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_ID    = 3'd1;
    localparam logic [2:0] ST_BAD_SEQ   = 3'd2;
    localparam logic [2:0] ST_NO_MORE   = 3'd3;
    localparam logic [2:0] ST_BAD_TYPE  = 3'd4;

    localparam logic [1:0] DEST_REQUESTER = 2'd0;
    localparam logic [1:0] DEST_CONTROL   = 2'd1;
    localparam logic [1:0] DEST_DATA      = 2'd2;

    // One classified message as it waits between front and back.
    typedef struct packed {
        cmd_t              cmd;
        logic [7:0]        chan;
        logic [7:0]        seq;
        logic [2:0]        ctype;
        logic              in_range;
        logic [SLOT_W-1:0] slot;
    } item_t;

endpackage

/* hdl/tcm_front.sv */
module tcm_front
    import tcm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [3:0] command,
    input  logic [7:0] channel_id,
    input  logic [7:0] sequence_req,
    input  logic [2:0] connection_type,
    output logic       busy,
    input  logic       pop,
    output logic       avail,
    output item_t      head
);

    item_t      q_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    item_t      cls;
    logic       push;

    // Channel id s+1 names slot s.
    always_comb
    begin
        cls.cmd      = command;
        cls.chan     = channel_id;
        cls.seq      = sequence_req;
        cls.ctype    = connection_type;
        cls.in_range = (channel_id != 8'd0) && (channel_id <= 8'(SLOTS));
        cls.slot     = SLOT_W'(channel_id - 8'd1);
    end

    assign busy  = (count_reg == 2'd2);
    assign push  = start && !busy;
    assign avail = (count_reg != 2'd0);
    assign head  = q_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

/* hdl/tcm_back.sv */
module tcm_back
    import tcm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        avail,
    input  item_t       head,
    output logic        pop,
    input  logic        cfg_we,
    input  logic [15:0] cfg_data,
    output logic        result_valid,
    output logic [2:0]  response_kind,
    output logic [2:0]  status,
    output logic [7:0]  reply_channel,
    output logic [7:0]  reply_sequence,
    output logic [2:0]  slot_index,
    output logic [1:0]  destination,
    output logic        last
);

    typedef enum logic {IDLE, WALK} state_t;

    state_t            state_reg;
    logic              walk_bcast_reg;
    logic [SLOT_W-1:0] idx_reg;
    logic [15:0]       hb_reg;
    logic              open_reg [SLOTS];
    logic [7:0]        rx_reg   [SLOTS];
    logic [7:0]        tx_reg   [SLOTS];
    logic [15:0]       cd_reg   [SLOTS];

    logic              free_found;
    logic [SLOT_W-1:0] free_idx;
    logic              hit;
    logic              more;

    assign pop = (state_reg == IDLE) && avail;

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        more       = 1'b0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!open_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
            if ((SLOT_W'(i) > idx_reg) && open_reg[i])
            begin
                more = 1'b1;
            end
        end
        hit = head.in_range && open_reg[head.slot];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= IDLE;
            walk_bcast_reg <= 1'b0;
            idx_reg        <= '0;
            hb_reg         <= 16'd120;
            result_valid   <= 1'b0;
            response_kind  <= '0;
            status         <= '0;
            reply_channel  <= '0;
            reply_sequence <= '0;
            slot_index     <= '0;
            destination    <= '0;
            last           <= 1'b0;
            for (int i = 0; i < SLOTS; i++)
            begin
                open_reg[i] <= 1'b0;
                rx_reg[i]   <= '0;
                tx_reg[i]   <= '0;
                cd_reg[i]   <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                hb_reg <= cfg_data;
            end
            result_valid   <= 1'b0;
            response_kind  <= '0;
            status         <= ST_OK;
            reply_channel  <= '0;
            reply_sequence <= '0;
            slot_index     <= '0;
            destination    <= DEST_REQUESTER;
            last           <= 1'b1;
            unique case (state_reg)
                IDLE:
                begin
                    if (avail)
                    begin
                        unique case (head.cmd)
                            CMD_CONNECT:
                            begin
                                result_valid  <= 1'b1;
                                response_kind <= KIND_CONNECT_RESP;
                                if (!free_found)
                                begin
                                    status <= ST_NO_MORE;
                                end
                                else if (head.ctype != 3'd0)
                                begin
                                    status <= ST_BAD_TYPE;
                                end
                                else
                                begin
                                    open_reg[free_idx] <= 1'b1;
                                    rx_reg[free_idx]   <= '0;
                                    tx_reg[free_idx]   <= '0;
                                    cd_reg[free_idx]   <= hb_reg;
                                    reply_channel      <= 8'(free_idx) + 8'd1;
                                    slot_index         <= free_idx;
                                    destination        <= DEST_CONTROL;
                                end
                            end
                            CMD_STATE_REQ, CMD_DISC_REQ:
                            begin
                                result_valid  <= 1'b1;
                                response_kind <= (head.cmd == CMD_STATE_REQ) ?
                                                 KIND_STATE_RESP : KIND_DISC_RESP;
                                reply_channel <= head.chan;
                                if (!hit)
                                begin
                                    status <= ST_BAD_ID;
                                end
                                else
                                begin
                                    slot_index  <= head.slot;
                                    destination <= DEST_CONTROL;
                                    if (head.cmd == CMD_STATE_REQ)
                                    begin
                                        cd_reg[head.slot] <= hb_reg;
                                    end
                                    else
                                    begin
                                        open_reg[head.slot] <= 1'b0;
                                        rx_reg[head.slot]   <= '0;
                                        tx_reg[head.slot]   <= '0;
                                        cd_reg[head.slot]   <= '0;
                                    end
                                end
                            end
                            CMD_DISC_RESP:
                            begin
                                if (hit)
                                begin
                                    open_reg[head.slot] <= 1'b0;
                                    rx_reg[head.slot]   <= '0;
                                    tx_reg[head.slot]   <= '0;
                                    cd_reg[head.slot]   <= '0;
                                end
                            end
                            CMD_TUNNEL_REQ:
                            begin
                                if (hit)
                                begin
                                    result_valid  <= 1'b1;
                                    response_kind <= KIND_TUNNEL_ACK;
                                    reply_channel <= head.chan;
                                    slot_index    <= head.slot;
                                    if (head.seq != rx_reg[head.slot])
                                    begin
                                        status      <= ST_BAD_SEQ;
                                        destination <= DEST_CONTROL;
                                    end
                                    else
                                    begin
                                        reply_sequence    <= rx_reg[head.slot];
                                        destination       <= DEST_DATA;
                                        rx_reg[head.slot] <= rx_reg[head.slot] + 8'd1;
                                    end
                                end
                            end
                            CMD_TUNNEL_ACK:
                            begin
                                if (hit && (head.seq == tx_reg[head.slot]))
                                begin
                                    tx_reg[head.slot] <= tx_reg[head.slot] + 8'd1;
                                end
                            end
                            CMD_SEARCH:
                            begin
                                result_valid  <= 1'b1;
                                response_kind <= KIND_SEARCH_RESP;
                            end
                            CMD_TICK, CMD_BROADCAST:
                            begin
                                state_reg      <= WALK;
                                walk_bcast_reg <= (head.cmd == CMD_BROADCAST);
                                idx_reg        <= '0;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                WALK:
                begin
                    if (open_reg[idx_reg])
                    begin
                        if (walk_bcast_reg)
                        begin
                            result_valid   <= 1'b1;
                            response_kind  <= KIND_TUNNEL_OUT;
                            reply_channel  <= 8'(idx_reg) + 8'd1;
                            reply_sequence <= tx_reg[idx_reg];
                            slot_index     <= idx_reg;
                            destination    <= DEST_DATA;
                            last           <= !more;
                        end
                        else if (cd_reg[idx_reg] == 16'd0)
                        begin
                            open_reg[idx_reg] <= 1'b0;
                            rx_reg[idx_reg]   <= '0;
                            tx_reg[idx_reg]   <= '0;
                        end
                        else
                        begin
                            cd_reg[idx_reg] <= cd_reg[idx_reg] - 16'd1;
                        end
                    end
                    if (idx_reg == SLOT_W'(SLOTS - 1))
                    begin
                        state_reg <= IDLE;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

endmodule

/* hdl/tunnel_connection_manager_top.sv */
// Channel    | Direction | Handshake              | Beat
// command    | in        | start && !busy         | command, channel_id, sequence_req,
//            |           |                        | connection_type
// result     | out       | result_valid, one cycle| response_kind .. last
// config     | in        | cfg_valid && cfg_ready | cfg_data (heartbeat_ticks)
//
// Tick and broadcast walk all eight slots in the back end, one per cycle, and
// no new command is taken until the walk ends. A two-entry queue sits between
// the front and back, and busy rises only when it is full.
// Reset clears all slots and loads heartbeat_ticks with 120.
// Results cannot be stalled; cfg_ready is always high.
module tunnel_connection_manager_top
    import tcm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [3:0]  command,
    input  logic [7:0]  channel_id,
    input  logic [7:0]  sequence_req,
    input  logic [2:0]  connection_type,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    output logic        result_valid,
    output logic [2:0]  response_kind,
    output logic [2:0]  status,
    output logic [7:0]  reply_channel,
    output logic [7:0]  reply_sequence,
    output logic [2:0]  slot_index,
    output logic [1:0]  destination,
    output logic        last
);

    logic  pop;
    logic  avail;
    item_t head;

    assign cfg_ready = 1'b1;

    tcm_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .command         (command),
        .channel_id      (channel_id),
        .sequence_req    (sequence_req),
        .connection_type (connection_type),
        .busy            (busy),
        .pop             (pop),
        .avail           (avail),
        .head            (head)
    );

    tcm_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .avail          (avail),
        .head           (head),
        .pop            (pop),
        .cfg_we         (cfg_valid && cfg_ready),
        .cfg_data       (cfg_data),
        .result_valid   (result_valid),
        .response_kind  (response_kind),
        .status         (status),
        .reply_channel  (reply_channel),
        .reply_sequence (reply_sequence),
        .slot_index     (slot_index),
        .destination    (destination),
        .last           (last)
    );

endmodule

/* verif/testbench.sv */
`timescale 1ns / 100ps

module testbench;
    import tcm_pkg::*;

    typedef struct packed {
        logic [2:0] kind;
        logic [2:0] status;
        logic [7:0] chan;
        logic [7:0] seq;
        logic [2:0] slot;
        logic [1:0] dest;
        logic       last;
    } reply_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [3:0]  command;
    logic [7:0]  channel_id;
    logic [7:0]  sequence_req;
    logic [2:0]  connection_type;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;
    logic        result_valid;
    logic [2:0]  response_kind;
    logic [2:0]  status;
    logic [7:0]  reply_channel;
    logic [7:0]  reply_sequence;
    logic [2:0]  slot_index;
    logic [1:0]  destination;
    logic        last;

    // Shadow of the connection table.
    logic [15:0] hb_ticks;
    logic        open_q [SLOTS];
    logic [7:0]  rx_seq [SLOTS];
    logic [7:0]  tx_seq [SLOTS];
    logic [15:0] alive  [SLOTS];

    reply_t      pending_replies [$];
    int          mismatch_count;
    int          idle_cycles = 0;
    bit          failed;

    tunnel_connection_manager_top i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .command         (command),
        .channel_id      (channel_id),
        .sequence_req    (sequence_req),
        .connection_type (connection_type),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .result_valid    (result_valid),
        .response_kind   (response_kind),
        .status          (status),
        .reply_channel   (reply_channel),
        .reply_sequence  (reply_sequence),
        .slot_index      (slot_index),
        .destination     (destination),
        .last            (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic reply_t make_reply(logic [2:0] k, logic [2:0] st, logic [7:0] ch,
                                          logic [7:0] sq, logic [2:0] sl, logic [1:0] d);
        reply_t r;
        r.kind = k;
        r.status = st;
        r.chan = ch;
        r.seq = sq;
        r.slot = sl;
        r.dest = d;
        r.last = 1'b0;
        return r;
    endfunction

    function automatic int lookup_slot(logic [7:0] ch);
        if (ch >= 1 && ch <= SLOTS && open_q[ch - 1])
            return ch - 1;
        return -1;
    endfunction

    function automatic void close_slot(int s);
        open_q[s] = 1'b0;
        rx_seq[s] = 8'd0;
        tx_seq[s] = 8'd0;
        alive[s] = 16'd0;
    endfunction

    // Updates the shadow table and queues the replies one command causes.
    function automatic void predict_replies(cmd_t cmd, logic [7:0] ch, logic [7:0] sq,
                                            logic [2:0] ctype);
        reply_t r [$];
        int s;
        s = -1;
        case (cmd)
            CMD_CONNECT:
            begin
                for (int i = SLOTS - 1; i >= 0; i--)
                    if (!open_q[i])
                        s = i;
                if (s < 0)
                    r.push_back(make_reply(KIND_CONNECT_RESP, ST_NO_MORE, 0, 0, 0,
                                           DEST_REQUESTER));
                else if (ctype != 0)
                    r.push_back(make_reply(KIND_CONNECT_RESP, ST_BAD_TYPE, 0, 0, 0,
                                           DEST_REQUESTER));
                else
                begin
                    open_q[s] = 1'b1;
                    rx_seq[s] = 8'd0;
                    tx_seq[s] = 8'd0;
                    alive[s] = hb_ticks;
                    r.push_back(make_reply(KIND_CONNECT_RESP, ST_OK, 8'(s + 1), 0, 3'(s),
                                           DEST_CONTROL));
                end
            end
            CMD_STATE_REQ:
            begin
                s = lookup_slot(ch);
                if (s < 0)
                    r.push_back(make_reply(KIND_STATE_RESP, ST_BAD_ID, ch, 0, 0,
                                           DEST_REQUESTER));
                else
                begin
                    alive[s] = hb_ticks;
                    r.push_back(make_reply(KIND_STATE_RESP, ST_OK, ch, 0, 3'(s),
                                           DEST_CONTROL));
                end
            end
            CMD_DISC_REQ:
            begin
                s = lookup_slot(ch);
                if (s < 0)
                    r.push_back(make_reply(KIND_DISC_RESP, ST_BAD_ID, ch, 0, 0,
                                           DEST_REQUESTER));
                else
                begin
                    r.push_back(make_reply(KIND_DISC_RESP, ST_OK, ch, 0, 3'(s),
                                           DEST_CONTROL));
                    close_slot(s);
                end
            end
            CMD_DISC_RESP:
            begin
                s = lookup_slot(ch);
                if (s >= 0)
                    close_slot(s);
            end
            CMD_TUNNEL_REQ:
            begin
                s = lookup_slot(ch);
                if (s >= 0)
                begin
                    if (sq != rx_seq[s])
                        r.push_back(make_reply(KIND_TUNNEL_ACK, ST_BAD_SEQ, ch, 0, 3'(s),
                                               DEST_CONTROL));
                    else
                    begin
                        r.push_back(make_reply(KIND_TUNNEL_ACK, ST_OK, ch, rx_seq[s], 3'(s),
                                               DEST_DATA));
                        rx_seq[s] = rx_seq[s] + 8'd1;
                    end
                end
            end
            CMD_TUNNEL_ACK:
            begin
                s = lookup_slot(ch);
                if (s >= 0 && sq == tx_seq[s])
                    tx_seq[s] = tx_seq[s] + 8'd1;
            end
            CMD_SEARCH:
                r.push_back(make_reply(KIND_SEARCH_RESP, ST_OK, 0, 0, 0, DEST_REQUESTER));
            CMD_TICK:
                for (int i = 0; i < SLOTS; i++)
                    if (open_q[i])
                    begin
                        if (alive[i] == 0)
                            close_slot(i);
                        else
                            alive[i] = alive[i] - 16'd1;
                    end
            CMD_BROADCAST:
                for (int i = 0; i < SLOTS; i++)
                    if (open_q[i])
                        r.push_back(make_reply(KIND_TUNNEL_OUT, ST_OK, 8'(i + 1), tx_seq[i],
                                               3'(i), DEST_DATA));
            default: ;
        endcase
        if (r.size() > 0)
            r[r.size() - 1].last = 1'b1;
        foreach (r[i])
            pending_replies.push_back(r[i]);
    endfunction

    // Sends one command; a random gap may follow to break up bursts.
    task automatic send_command(cmd_t cmd, logic [7:0] ch, logic [7:0] sq,
                                logic [2:0] ctype);
        start <= 1'b1;
        command <= cmd;
        channel_id <= ch;
        sequence_req <= sq;
        connection_type <= ctype;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_replies(cmd, ch, sq, ctype);
        @(negedge clk);
        if ($urandom_range(0, 4) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (pending_replies.size() != 0)
            @(negedge clk);
        // Commands with no reply may still be walking the table.
        repeat (30) @(negedge clk);
    endtask

    task automatic write_heartbeat(logic [15:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        hb_ticks = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_directed();
        send_command(CMD_SEARCH, 8'hff, 8'hff, 3'd7);
        send_command(CMD_BROADCAST, 0, 0, 0);
        send_command(CMD_CONNECT, 0, 0, 3'd1);
        send_command(CMD_CONNECT, 0, 0, 3'd4);
        for (int i = 0; i < SLOTS; i++)
            send_command(CMD_CONNECT, 8'hff, 8'hff, 3'd0);
        send_command(CMD_CONNECT, 0, 0, 3'd0);
        send_command(CMD_STATE_REQ, 8'd0, 0, 0);
        send_command(CMD_STATE_REQ, 8'd9, 0, 0);
        send_command(CMD_STATE_REQ, 8'd8, 0, 0);
        send_command(CMD_TUNNEL_REQ, 8'd1, 8'd0, 0);
        send_command(CMD_TUNNEL_REQ, 8'd1, 8'd5, 0);
        send_command(CMD_TUNNEL_ACK, 8'd2, 8'd0, 0);
        send_command(CMD_BROADCAST, 0, 0, 0);
        send_command(CMD_DISC_REQ, 8'd3, 0, 0);
        send_command(CMD_DISC_REQ, 8'd3, 0, 0);
        send_command(CMD_DISC_RESP, 8'd4, 0, 0);
        send_command(4'd15, 8'd1, 0, 0);
        send_command(CMD_TICK, 0, 0, 0);
    endtask

    task automatic test_heartbeat_expiry();
        write_heartbeat(16'd0);
        send_command(CMD_CONNECT, 0, 0, 0);
        send_command(CMD_TICK, 0, 0, 0);
        send_command(CMD_BROADCAST, 0, 0, 0);
        write_heartbeat(16'd2);
        for (int i = 0; i < 4; i++)
        begin
            send_command(CMD_TICK, 0, 0, 0);
            send_command(CMD_BROADCAST, 0, 0, 0);
        end
        write_heartbeat(16'hffff);
    endtask

    task automatic test_random(int count);
        int      pick;
        int      s;
        cmd_t    cmd;
        logic [7:0] ch;
        logic [7:0] sq;
        for (int n = 0; n < count; n++)
        begin
            ch = 8'($urandom_range(1, SLOTS));
            s = ch - 1;
            pick = $urandom_range(0, 99);
            if (pick < 14)
                cmd = CMD_CONNECT;
            else if (pick < 24)
                cmd = CMD_STATE_REQ;
            else if (pick < 30)
                cmd = CMD_DISC_REQ;
            else if (pick < 34)
                cmd = CMD_DISC_RESP;
            else if (pick < 58)
                cmd = CMD_TUNNEL_REQ;
            else if (pick < 72)
                cmd = CMD_TUNNEL_ACK;
            else if (pick < 76)
                cmd = CMD_SEARCH;
            else if (pick < 84)
                cmd = CMD_TICK;
            else if (pick < 95)
                cmd = CMD_BROADCAST;
            else
                cmd = cmd_t'($urandom_range(9, 15));
            // Mostly matching sequence numbers so counters advance far.
            if (cmd == CMD_TUNNEL_REQ && $urandom_range(0, 4) != 0)
                sq = rx_seq[s];
            else if (cmd == CMD_TUNNEL_ACK && $urandom_range(0, 4) != 0)
                sq = tx_seq[s];
            else
                sq = 8'($urandom);
            if ($urandom_range(0, 9) == 0)
                ch = 8'($urandom);
            send_command(cmd, ch, sq, (cmd == CMD_CONNECT && $urandom_range(0, 4) != 0)
                         ? 3'd0 : 3'($urandom));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        command = '0;
        channel_id = '0;
        sequence_req = '0;
        connection_type = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        hb_ticks = 16'd120;
        for (int i = 0; i < SLOTS; i++)
            close_slot(i);
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_heartbeat_expiry();
        test_random(120);
        write_heartbeat(16'd3);
        test_random(120);
        write_heartbeat(16'd1);
        test_random(100);
        wait_drained();
        if (!failed && pending_replies.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Results cannot be stalled, so every strobe is checked as it comes.
    always @(posedge clk)
    begin
        reply_t got;
        reply_t want;
        if (rst_n && result_valid)
        begin
            got = '{response_kind, status, reply_channel, reply_sequence, slot_index,
                    destination, last};
            if (pending_replies.size() == 0)
            begin
                failed = 1'b1;
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected reply %h", got);
            end
            else
            begin
                want = pending_replies.pop_front();
                if (got !== want)
                begin
                    failed = 1'b1;
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("reply mismatch: expected %h actual %h", want, got);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

endmodule
